FILE: hw/rtl/utf8_to_utf32_decoder_assert.svh
// Assertion macros for the UTF-8 to UTF-32 decoder.
// Depends on nothing; included by the top level only.
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define U8DEC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec assertion failed");

// Next-cycle implication, disabled in reset.
`define U8DEC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec assertion failed");

`endif

FILE: hw/rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned AccW   = 18;
  localparam int unsigned CntW   = 3;   // results per request: 0..4

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [AccW-1:0]  acc_t;
  typedef logic [1:0]       seq_cnt_t;
  typedef logic [CntW-1:0]  res_cnt_t;

  localparam cp_t   REPL_CHAR   = cp_t'(63);   // '?'
  localparam byte_t CONT_MASK   = 8'hC0;
  localparam byte_t CONT_TAG    = 8'h80;
  localparam byte_t LEAD2_LO    = 8'hC0;
  localparam byte_t LEAD3_LO    = 8'hE0;
  localparam byte_t LEAD4_LO    = 8'hF0;
  localparam byte_t LEAD_BAD_LO = 8'hF8;
  localparam byte_t BITS6_MASK  = 8'h3F;
  localparam byte_t LEAD2_MASK  = 8'h1F;
  localparam byte_t LEAD3_MASK  = 8'h0F;
  localparam byte_t LEAD4_MASK  = 8'h07;

endpackage

FILE: hw/rtl/u8dec_if.sv
// Valid/ready channel interfaces for the decoder: byte requests in,
// code point results out. Depends on u8dec_pkg.
`timescale 1ns / 1ps

interface u8dec_in_if;
  import u8dec_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface u8dec_out_if;
  import u8dec_pkg::*;
  logic valid;
  logic ready;
  cp_t  code_point;
  logic replaced;
  logic run_last;
  modport source (output valid, code_point, replaced, run_last, input ready);
  modport sink   (input valid, code_point, replaced, run_last, output ready);
endinterface

FILE: hw/rtl/utf8_to_utf32_decoder.sv
// Streaming UTF-8 to UTF-32 decoder, top level.
// Depends on u8dec_pkg, u8dec_if.sv and utf8_to_utf32_decoder_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   byte_in  : valid/ready requests, one UTF-8 byte each, stream_end set on
//              the final byte of a stream (an open sequence is then flushed).
//   cp_out   : valid/ready results, one code point each; replaced marks a
//              '?' standing for a bad byte, run_last marks the final result
//              caused by one request.
//   Results are registered and start in the cycle after their request is accepted.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and cp_out.ready is high. A byte that gives k results (up to 4) holds the
//   result register until all are taken (one per cycle while cp_out.ready is
//   high); the next byte is accepted in the cycle the last is taken. Bytes
//   giving no result (lead and middle continuation bytes) pass at one per cycle.
//   Reset: synchronous, active high; clears the open sequence and drops
//   any results not yet taken.
//   Receiver stall: results hold in the register and byte_in.ready stays
//   low until the last pending result of the current request is taken.

module utf8_to_utf32_decoder (
  input  logic               clk,
  input  logic               rst,
  u8dec_in_if.sink           byte_in,
  u8dec_out_if.source        cp_out
);
  import u8dec_pkg::*;

  // Open sequence state.
  byte_t    lead_byte;
  acc_t     gathered_bits;
  seq_cnt_t bytes_expected;
  seq_cnt_t bytes_gathered;

  // Result burst register.
  res_cnt_t rem;        // results still to deliver
  res_cnt_t mid_rem;    // value of rem at which the non-flush result goes out
  logic     mid_valid;
  cp_t      mid_cp;
  logic     mid_rep;

  // Next values.
  byte_t    lead_byte_next;
  acc_t     gathered_bits_next;
  seq_cnt_t bytes_expected_next;
  seq_cnt_t bytes_gathered_next;
  res_cnt_t rem_next;
  res_cnt_t mid_rem_next;
  logic     mid_valid_next;
  cp_t      mid_cp_next;
  logic     mid_rep_next;

  // Decode scratch.
  byte_t    b;
  logic     is_cont;
  logic     seq_open;
  logic     [23:0] acc_wide;
  seq_cnt_t n_pre;
  seq_cnt_t n_post;
  logic     accept;
  logic     take;

  assign accept = byte_in.valid && byte_in.ready;
  assign take   = cp_out.valid && cp_out.ready;

  assign byte_in.ready = (rem == '0) || (rem == res_cnt_t'(1) && cp_out.ready);

  assign cp_out.valid      = (rem != '0);
  assign cp_out.run_last   = (rem == res_cnt_t'(1));
  assign cp_out.code_point = (mid_valid && rem == mid_rem) ? mid_cp : REPL_CHAR;
  assign cp_out.replaced   = (mid_valid && rem == mid_rem) ? mid_rep : 1'b1;

  always_comb begin
    b        = byte_in.data_byte;
    is_cont  = ((b & CONT_MASK) == CONT_TAG);
    seq_open = (bytes_expected != '0);
    acc_wide = {gathered_bits, b[5:0]};

    lead_byte_next      = lead_byte;
    gathered_bits_next  = gathered_bits;
    bytes_expected_next = bytes_expected;
    bytes_gathered_next = bytes_gathered;
    n_pre               = '0;
    n_post              = '0;
    mid_valid_next      = 1'b0;
    mid_cp_next         = REPL_CHAR;
    mid_rep_next        = 1'b1;

    if (seq_open && is_cont) begin
      if ({1'b0, bytes_gathered} + 3'd1 >= {1'b0, bytes_expected}) begin
        mid_valid_next      = 1'b1;
        mid_cp_next         = acc_wide[CpW-1:0];
        mid_rep_next        = 1'b0;
        lead_byte_next      = '0;
        gathered_bits_next  = '0;
        bytes_expected_next = '0;
        bytes_gathered_next = '0;
      end else begin
        gathered_bits_next  = acc_wide[AccW-1:0];
        bytes_gathered_next = bytes_gathered + seq_cnt_t'(1);
      end
    end else begin
      // A broken sequence flushes one '?' per held byte, then b starts afresh.
      if (seq_open) begin
        n_pre               = (bytes_gathered == 2'd3) ? 2'd3 : bytes_gathered + 2'd1;
        lead_byte_next      = '0;
        gathered_bits_next  = '0;
        bytes_expected_next = '0;
        bytes_gathered_next = '0;
      end
      if (b < CONT_TAG) begin
        mid_valid_next = 1'b1;
        mid_cp_next    = cp_t'(b);
        mid_rep_next   = 1'b0;
      end else if (b < LEAD2_LO || b >= LEAD_BAD_LO) begin
        mid_valid_next = 1'b1;
      end else begin
        lead_byte_next      = b;
        bytes_gathered_next = '0;
        if (b < LEAD3_LO) begin
          gathered_bits_next  = acc_t'(b & LEAD2_MASK);
          bytes_expected_next = 2'd1;
        end else if (b < LEAD4_LO) begin
          gathered_bits_next  = acc_t'(b & LEAD3_MASK);
          bytes_expected_next = 2'd2;
        end else begin
          gathered_bits_next  = acc_t'(b & LEAD4_MASK);
          bytes_expected_next = 2'd3;
        end
      end
    end

    // Truncated at stream end.
    if (byte_in.stream_end && bytes_expected_next != '0) begin
      n_post = (bytes_gathered_next == 2'd3) ? 2'd3 : bytes_gathered_next + 2'd1;
      lead_byte_next      = '0;
      gathered_bits_next  = '0;
      bytes_expected_next = '0;
      bytes_gathered_next = '0;
    end

    rem_next     = res_cnt_t'(n_pre) + res_cnt_t'(mid_valid_next) + res_cnt_t'(n_post);
    mid_rem_next = rem_next - res_cnt_t'(n_pre);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte      <= '0;
      gathered_bits  <= '0;
      bytes_expected <= '0;
      bytes_gathered <= '0;
      rem            <= '0;
      mid_valid      <= 1'b0;
    end else if (accept) begin
      lead_byte      <= lead_byte_next;
      gathered_bits  <= gathered_bits_next;
      bytes_expected <= bytes_expected_next;
      bytes_gathered <= bytes_gathered_next;
      rem            <= rem_next;
      mid_valid      <= mid_valid_next;
    end else if (take) begin
      rem <= rem - res_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rem <= mid_rem_next;
      mid_cp  <= mid_cp_next;
      mid_rep <= mid_rep_next;
    end
  end

`include "utf8_to_utf32_decoder_assert.svh"

  // No sequence open means nothing gathered.
  `U8DEC_ASSERT_IMP(a_idle_clean, clk, rst, bytes_expected == '0,
                    bytes_gathered == '0 && gathered_bits == '0)
  // A sequence never holds as many continuation bytes as it needs.
  `U8DEC_ASSERT_IMP(a_gather_bound, clk, rst, bytes_expected != '0,
                    bytes_gathered < bytes_expected)
  // After the last result of a request is taken, new results need a new request.
  `U8DEC_ASSERT_NXT(a_no_invented, clk, rst, take && cp_out.run_last && !accept, !cp_out.valid)
  // A replacement result always carries '?'.
  `U8DEC_ASSERT_IMP(a_repl_char, clk, rst, cp_out.valid && cp_out.replaced,
                    cp_out.code_point == REPL_CHAR)

endmodule

FILE: bench/utf8_to_utf32_decoder_tb.sv
// Self-checking bench for the UTF-8 to UTF-32 decoder: directed and random byte
// streams, with a scoreboard that predicts the code points and replacements.
// Depends on u8dec_pkg, u8dec_if.sv and utf8_to_utf32_decoder.sv.
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_tb;
  import u8dec_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomReqs = 480;
  localparam int unsigned QuietFrom  = 400;

  typedef struct {
    cp_t  code_point;
    logic replaced;
    logic run_last;
  } cp_result_t;

  // Tracks the open sequence and holds the code points still owed by the DUT.
  class cp_scoreboard;
    byte_t      lead;
    acc_t       gathered;
    seq_cnt_t   need;
    seq_cnt_t   got;
    cp_result_t expected_q[$];
    cp_result_t step_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      lead     = '0;
      gathered = '0;
      need     = '0;
      got      = '0;
    endfunction

    function void emit(cp_t cp, logic rep);
      cp_result_t r;
      r.code_point = cp;
      r.replaced   = rep;
      r.run_last   = 1'b0;
      if (step_q.size() < 4) step_q.push_back(r);
    endfunction

    // one '?' for the lead plus one per gathered continuation
    function void flush_seq();
      for (int i = 0; i <= int'(got) && i < 3; i++) emit(REPL_CHAR, 1'b1);
      clear_seq();
    endfunction

    function void open_seq(byte_t b, seq_cnt_t n, byte_t mask);
      lead     = b;
      gathered = acc_t'(b & mask);
      need     = n;
      got      = '0;
    endfunction

    function void note_request(byte_t b, logic fin);
      logic consumed;
      cp_t  joined;
      consumed = 1'b0;
      step_q.delete();
      if (need != 0) begin
        if ((b & CONT_MASK) == CONT_TAG) begin
          joined   = cp_t'({gathered, 6'(b & BITS6_MASK)});
          consumed = 1'b1;
          if (int'(got) + 1 >= int'(need)) begin
            emit(joined, 1'b0);
            clear_seq();
          end else begin
            gathered = acc_t'(joined);
            got      = got + 1'b1;
          end
        end else begin
          flush_seq();
        end
      end
      if (!consumed) begin
        if (b < CONT_TAG)          emit(cp_t'(b), 1'b0);
        else if (b < LEAD2_LO)     emit(REPL_CHAR, 1'b1);
        else if (b < LEAD3_LO)     open_seq(b, 2'd1, LEAD2_MASK);
        else if (b < LEAD4_LO)     open_seq(b, 2'd2, LEAD3_MASK);
        else if (b < LEAD_BAD_LO)  open_seq(b, 2'd3, LEAD4_MASK);
        else                       emit(REPL_CHAR, 1'b1);
      end
      if (fin && need != 0) flush_seq();
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_result(cp_t cp, logic rep, logic last);
      cp_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: code_point %0h replaced %0b run_last %0b",
               cp, rep, last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (cp !== exp_r.code_point) begin
        $error("code_point: expected %0h, actual %0h", exp_r.code_point, cp);
        errors++;
      end
      if (rep !== exp_r.replaced) begin
        $error("replaced: expected %0b, actual %0b", exp_r.replaced, rep);
        errors++;
      end
      if (last !== exp_r.run_last) begin
        $error("run_last: expected %0b, actual %0b", exp_r.run_last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic quiet;
  int unsigned stall_cycles;

  u8dec_in_if  byte_in_if ();
  u8dec_out_if cp_out_if ();

  cp_scoreboard sb = new();

  utf8_to_utf32_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in_if.sink),
    .cp_out  (cp_out_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // both handshakes are seen here, requests first, plus the stall watchdog
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (byte_in_if.valid && byte_in_if.ready) begin
        sb.note_request(byte_in_if.data_byte, byte_in_if.stream_end);
        moved = 1'b1;
      end
      if (cp_out_if.valid && cp_out_if.ready) begin
        sb.check_result(cp_out_if.code_point, cp_out_if.replaced, cp_out_if.run_last);
        moved = 1'b1;
      end
      if (moved) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $error("no handshake for %0d cycles", StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: ready in random stretches, with random low bursts while not quiet
  initial begin
    cp_out_if.ready = 1'b0;
    wait (!rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        cp_out_if.ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      cp_out_if.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input byte_t b, input logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      byte_in_if.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    byte_in_if.valid      = 1'b1;
    byte_in_if.data_byte  = b;
    byte_in_if.stream_end = fin;
    do @(posedge clk); while (!byte_in_if.ready);
    @(negedge clk);
  endtask

  function automatic byte_t cont_byte();
    return byte_t'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic byte_t lead_byte_of(int unsigned len);
    case (len)
      1:       return byte_t'($urandom_range(8'h00, 8'h7F));
      2:       return byte_t'($urandom_range(LEAD2_LO, LEAD3_LO - 1));
      3:       return byte_t'($urandom_range(LEAD3_LO, LEAD4_LO - 1));
      default: return byte_t'($urandom_range(LEAD4_LO, LEAD_BAD_LO - 1));
    endcase
  endfunction

  // any byte that is not a continuation
  function automatic byte_t breaking_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    if ((b & CONT_MASK) == CONT_TAG) b = b ^ 8'h40;
    return b;
  endfunction

  // {stream_end, byte}
  logic [8:0] directed_reqs [25] = '{
    9'h000, 9'h07F,                     // ASCII extremes
    9'h080, 9'h0BF,                     // stray continuations
    9'h0F8, 9'h1FF,                     // invalid leads, end with nothing open
    9'h0C0, 9'h080,                     // lowest 2-byte form
    9'h0EF, 9'h0BF, 9'h0BF,             // highest 3-byte form
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,     // highest 4-byte form
    9'h0F0, 9'h090, 9'h080, 9'h041,     // broken after two continuations
    9'h0E2, 9'h182,                     // truncated by stream end
    9'h0F0, 9'h090, 9'h080, 9'h1C3      // broken, then new lead cut by end
  };

  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned n_cont;
    logic        fin;

    rst                   = 1'b1;
    quiet                 = 1'b0;
    byte_in_if.valid      = 1'b0;
    byte_in_if.data_byte  = '0;
    byte_in_if.stream_end = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_reqs[i]) send_byte(directed_reqs[i][7:0], directed_reqs[i][8]);

    sent = 0;
    while (sent < RandomReqs) begin
      if (sent >= QuietFrom) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed character, stream sometimes ends on it
        len = $urandom_range(1, 4);
        fin = ($urandom_range(0, 7) == 0);
        send_byte(lead_byte_of(len), fin && len == 1);
        sent++;
        for (int i = 1; i < len; i++) begin
          send_byte(cont_byte(), fin && i == len - 1);
          sent++;
        end
      end else if (kind < 85) begin
        // partial sequence, broken by a non-continuation or cut by stream end
        len    = $urandom_range(2, 4);
        n_cont = $urandom_range(0, len - 2);
        fin    = 1'($urandom_range(0, 1));
        send_byte(lead_byte_of(len), fin && n_cont == 0);
        sent++;
        for (int i = 0; i < n_cont; i++) begin
          send_byte(cont_byte(), fin && i == n_cont - 1);
          sent++;
        end
        if (!fin) begin
          send_byte(breaking_byte(), $urandom_range(0, 3) == 0);
          sent++;
        end
      end else begin
        send_byte(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    byte_in_if.valid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
